/* rtl/assert_macros.svh */
// assertion helpers for the rtl files, included by run_literal_rle_encoder
// expects signals named clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rle_pkg.sv */
// shared types and constants of the run/literal encoder
// no dependencies
package rle_pkg;

  // encoded bytes per result word
  localparam int unsigned BYTES_PER_WORD = 4;
  // shortest run that is coded as a run
  localparam int unsigned MIN_RUN = 3;
  // control byte base for runs, a run of n codes as base + n - MIN_RUN
  localparam logic [7:0] RUN_CTL_BASE = 8'h80;
  localparam logic [7:0] RUN_CTL_BIAS = RUN_CTL_BASE - 8'(MIN_RUN);

  // request from the sequencer to the word packer
  typedef struct packed {
    logic       byte_vld;  // one encoded byte offered
    logic [7:0] data;      // the encoded byte
    logic       flush;     // close the word of this transaction
    logic       last;      // the transaction ends the block
  } pk_req_t;

endpackage

/* rtl/rle_packer.sv */
// packs the encoded byte stream four bytes to a word and holds the output register
// depends on rle_pkg
module rle_packer (
  input  logic             clk,
  input  logic             rst_n,
  input  rle_pkg::pk_req_t req,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_packed_bytes,
  output logic [2:0]       out_byte_count,
  output logic             out_end_of_item,
  output logic             out_end_of_block
);
  import rle_pkg::*;

  localparam logic [2:0] FULL = 3'(BYTES_PER_WORD);

  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;
  logic [2:0]  out_cnt_r;
  logic        out_eoi_r, out_eob_r;
  logic        load_ok, push;

  // output register can take a word this cycle
  assign load_ok = !out_valid_r || !out_stall;

  always_comb begin
    if (req.byte_vld) begin
      ready = (cnt_r != FULL) || load_ok;
    end else begin
      ready = (cnt_r == 3'd0) || load_ok;
    end
  end

  // a word leaves when a fifth byte arrives or the transaction closes with bytes held
  assign push = ready && ((req.byte_vld && cnt_r == FULL) || (req.flush && cnt_r != 3'd0));

  // accumulator update
  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (req.byte_vld && ready) begin
      if (cnt_r == FULL) begin
        acc_nxt = {24'd0, req.data};
        cnt_nxt = 3'd1;
      end else begin
        acc_nxt[8*cnt_r[1:0] +: 8] = req.data;
        cnt_nxt = cnt_r + 3'd1;
      end
    end else if (req.flush && ready) begin
      acc_nxt = '0;
      cnt_nxt = 3'd0;
    end
  end

  // output valid
  always_comb begin
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= acc_r;
      out_cnt_r  <= cnt_r;
      out_eoi_r  <= req.flush;
      out_eob_r  <= req.flush && req.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_packed_bytes = out_data_r;
  assign out_byte_count   = out_cnt_r;
  assign out_end_of_item  = out_eoi_r;
  assign out_end_of_block = out_eob_r;

endmodule

/* rtl/run_literal_rle_encoder.sv */
// top level of the run/literal byte encoder: run tracking, literal store, sequencer
// depends on rle_pkg, rle_packer and assert_macros.svh
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid in_stall in_data_byte ...     | byte in
//  output  | out_valid out_stall out_packed_bytes ..| words out
//
// a byte that extends the open run leaves the sequencer idle unless it ends the block; any
// other byte goes to the close step, which writes each short-run byte to the store, sends
// each encoded byte, starts a pass for each long run or literal chunk without a full store,
// and makes a close pass on the block's last byte. literal flushes read the store one entry
// a cycle while the packer is ready. output stalls hold the sequencer until the packer drains.
// reset is synchronous; the store needs no clearing pass, entries are read only after writing.
module run_literal_rle_encoder #(
  parameter int unsigned MAX_LITERAL = 128,
  parameter int unsigned MAX_RUN     = 130
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_of_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_packed_bytes,
  output logic [2:0]  out_byte_count,
  output logic        out_end_of_item,
  output logic        out_end_of_block
);
  import rle_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW  = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
  localparam int unsigned CW  = $clog2(MAX_LITERAL + 1);
  localparam int unsigned RLW = $clog2(MAX_RUN + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_LCTL,
    S_LDATA,
    S_RUNCTL,
    S_RUNVAL
  } state_t;

  state_t         state_r, state_nxt;
  logic           cur_last_r, cur_last_nxt;
  logic           final_r, final_nxt;
  logic [7:0]     run_val_r, run_val_nxt;
  logic [RLW-1:0] run_len_r, run_len_nxt;
  logic [7:0]     close_val_r, close_val_nxt;
  logic [RLW-1:0] close_len_r, close_len_nxt;
  logic [CW-1:0]  lit_cnt_r, lit_cnt_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;

  logic [7:0]     lit_mem [MAX_LITERAL];
  logic [7:0]     rdata_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;

  pk_req_t        pk_req;
  logic           pk_ready;
  logic           extend;

  // byte continues the open run
  assign extend = (run_len_r != '0) && (in_data_byte == run_val_r) &&
                  (run_len_r < RLW'(MAX_RUN));

  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_last_nxt  = cur_last_r;
    final_nxt     = final_r;
    run_val_nxt   = run_val_r;
    run_len_nxt   = run_len_r;
    close_val_nxt = close_val_r;
    close_len_nxt = close_len_r;
    lit_cnt_nxt   = lit_cnt_r;
    idx_nxt       = idx_r;
    mem_we        = 1'b0;
    mem_waddr     = lit_cnt_r[AW-1:0];
    mem_raddr     = idx_r;
    pk_req        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_last_nxt = in_last_of_block;
          if (extend) begin
            run_len_nxt = run_len_r + RLW'(1);
            if (in_last_of_block) begin
              state_nxt = S_CLOSE;
            end
          end else begin
            close_val_nxt = run_val_r;
            close_len_nxt = run_len_r;
            run_val_nxt   = in_data_byte;
            run_len_nxt   = RLW'(1);
            state_nxt     = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (close_len_r >= RLW'(MIN_RUN)) begin
          // long run: pending literals go first
          if (lit_cnt_r != '0) begin
            state_nxt = S_LCTL;
          end else begin
            state_nxt = S_RUNCTL;
          end
        end else if (close_len_r != '0) begin
          // short run: one literal into the store per cycle
          mem_we        = 1'b1;
          lit_cnt_nxt   = lit_cnt_r + CW'(1);
          close_len_nxt = close_len_r - RLW'(1);
          if (lit_cnt_r + CW'(1) == CW'(MAX_LITERAL)) begin
            state_nxt = S_LCTL;
          end
        end else if (final_r && lit_cnt_r != '0) begin
          state_nxt = S_LCTL;
        end else if (!final_r && cur_last_r) begin
          // block end: close the open run, which holds this byte
          close_val_nxt = run_val_r;
          close_len_nxt = run_len_r;
          run_val_nxt   = 8'd0;
          run_len_nxt   = '0;
          final_nxt     = 1'b1;
        end else begin
          pk_req.flush = 1'b1;
          pk_req.last  = cur_last_r;
          if (pk_ready) begin
            final_nxt    = 1'b0;
            cur_last_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_LCTL: begin
        // literal chunk header, store entry 0 is fetched meanwhile
        pk_req.byte_vld = 1'b1;
        pk_req.data     = 8'(lit_cnt_r - CW'(1));
        mem_raddr       = '0;
        if (pk_ready) begin
          idx_nxt   = '0;
          state_nxt = S_LDATA;
        end
      end
      S_LDATA: begin
        pk_req.byte_vld = 1'b1;
        pk_req.data     = rdata_r;
        if (pk_ready) begin
          if (CW'(idx_r) + CW'(1) == lit_cnt_r) begin
            lit_cnt_nxt = '0;
            state_nxt   = S_CLOSE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            mem_raddr = idx_r + AW'(1);
          end
        end
      end
      S_RUNCTL: begin
        pk_req.byte_vld = 1'b1;
        pk_req.data     = 8'(close_len_r) + RUN_CTL_BIAS;
        if (pk_ready) begin
          state_nxt = S_RUNVAL;
        end
      end
      S_RUNVAL: begin
        pk_req.byte_vld = 1'b1;
        pk_req.data     = close_val_r;
        if (pk_ready) begin
          close_len_nxt = '0;
          state_nxt     = S_CLOSE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_last_r  <= 1'b0;
      final_r     <= 1'b0;
      run_val_r   <= 8'd0;
      run_len_r   <= '0;
      close_val_r <= 8'd0;
      close_len_r <= '0;
      lit_cnt_r   <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_last_r  <= cur_last_nxt;
      final_r     <= final_nxt;
      run_val_r   <= run_val_nxt;
      run_len_r   <= run_len_nxt;
      close_val_r <= close_val_nxt;
      close_len_r <= close_len_nxt;
      lit_cnt_r   <= lit_cnt_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // literal store with a registered read port; read data is used only in the literal states, never while writing
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lit_mem[mem_waddr] <= close_val_r;
    end
    rdata_r <= lit_mem[mem_raddr];
  end

  rle_packer u_packer (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (pk_req),
    .ready            (pk_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_bytes (out_packed_bytes),
    .out_byte_count   (out_byte_count),
    .out_end_of_item  (out_end_of_item),
    .out_end_of_block (out_end_of_block)
  );

  // checks
  `CHK_ALWAYS(a_lit_cnt_range, lit_cnt_r <= CW'(MAX_LITERAL), "literal count overflow")
  `CHK_IMPLY(a_idle_clean, state_r == S_IDLE, close_len_r == '0 && !final_r, "idle with work left")
  `CHK_IMPLY(a_word_count, out_valid, out_byte_count != 3'd0 && out_byte_count <= 3'd4, "bad byte count")
  `CHK_IMPLY(a_eob_eoi, out_valid && out_end_of_block, out_end_of_item, "block end not item end")
  `CHK_NEXT(a_last_flushes, in_valid && !in_stall && in_last_of_block, state_r == S_CLOSE, "last byte not closed")

endmodule
